// File: rtl/core/tcqe_pkg.sv
// ----------------------------------------------------------------------------
// tcqe_pkg
// shared types and constants of the three-class queue engine
// ----------------------------------------------------------------------------
`default_nettype none
package tcqe_pkg;
  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned KEY_W = 7;
  localparam int unsigned TAG_W = 8;
  localparam int unsigned ENT_W = KEY_W + TAG_W;

  localparam logic [1:0] CLS_NONE  = 2'd0;
  localparam logic [1:0] CLS_DEQUE = 2'd1;
  localparam logic [1:0] CLS_FIFO  = 2'd2;
  localparam logic [1:0] CLS_PRIO  = 2'd3;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_SERV  = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_BAD_CLS  = 3'd4
  } status_t;

  // command broadcast along the priority cell chain
  typedef struct packed {
    logic             ins;   // insert new entry
    logic             pop;   // remove head, shift toward head
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } pq_cmd_t;
endpackage
`default_nettype wire

// File: rtl/core/tcqe_pq_cell.sv
// ----------------------------------------------------------------------------
// tcqe_pq_cell
// one slot of the sorted priority list
// ----------------------------------------------------------------------------
`default_nettype none
module tcqe_pq_cell (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire tcqe_pkg::pq_cmd_t     cmd,
  // neighbor toward head
  input  wire                        prev_valid,
  input  wire                        prev_keep,   // insertion point is behind prev
  input  wire                        prev_gt,     // prev key is above the new key
  input  wire  [tcqe_pkg::ENT_W-1:0] prev_ent,
  // neighbor toward tail
  input  wire                        next_valid,
  input  wire  [tcqe_pkg::ENT_W-1:0] next_ent,
  output logic                       valid,
  output logic                       keep,
  output logic                       key_gt,
  output logic [tcqe_pkg::ENT_W-1:0] ent
);
  logic                       valid_r, valid_nxt;
  logic [tcqe_pkg::ENT_W-1:0] ent_r, ent_nxt;
  logic [tcqe_pkg::KEY_W-1:0] my_key;

  assign my_key = ent_r[tcqe_pkg::ENT_W-1 -: tcqe_pkg::KEY_W];
  assign key_gt = valid_r & (my_key > cmd.key);
  // first holder of an equal key keeps its place, the new entry goes after it
  assign keep   = key_gt | (valid_r & (my_key == cmd.key) & prev_gt);

  always_comb begin
    valid_nxt = valid_r;
    ent_nxt   = ent_r;
    if (cmd.pop) begin
      valid_nxt = next_valid;
      ent_nxt   = next_ent;
    end else if (cmd.ins && !keep) begin
      if (prev_keep) begin
        valid_nxt = 1'b1;
        ent_nxt   = {cmd.key, cmd.tag};
      end else if (prev_valid) begin
        valid_nxt = 1'b1;
        ent_nxt   = prev_ent;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end
  always_ff @(posedge clk) ent_r <= ent_nxt;

  assign valid = valid_r;
  assign ent   = ent_r;
endmodule
`default_nettype wire

// File: rtl/core/tcqe_ring.sv
// ----------------------------------------------------------------------------
// tcqe_ring
// circular buffer with front pointer, used as deque or fifo
// ----------------------------------------------------------------------------
`default_nettype none
module tcqe_ring #(
  parameter int unsigned DEPTH = tcqe_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        push,
  input  wire                        pop,
  input  wire                        at_rear,
  input  wire  [tcqe_pkg::ENT_W-1:0] wr_ent,
  output logic [tcqe_pkg::ENT_W-1:0] rd_ent,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH+1);
  logic [tcqe_pkg::ENT_W-1:0] mem [DEPTH];
  logic [tcqe_pkg::ENT_W-1:0] rd_r;
  logic [AW-1:0] front_r, front_nxt, rear_idx, last_idx, wr_idx, rd_idx;
  logic [CW-1:0] cnt_r, cnt_nxt;

  function automatic logic [AW-1:0] wrap(input logic [CW:0] v);
    logic [CW:0] r;
    r = (v >= (CW+1)'(DEPTH)) ? v - (CW+1)'(DEPTH) : v;
    return r[AW-1:0];
  endfunction

  assign rear_idx = wrap({1'b0, cnt_r} + (CW+1)'(front_r));
  // only used on a pop, so the count is at least one
  assign last_idx = wrap({1'b0, cnt_r} + (CW+1)'(front_r) - (CW+1)'(1));
  assign front_nxt = push & ~at_rear ? wrap((CW+1)'(front_r) + (CW+1)'(DEPTH - 1)) :
                     pop  & ~at_rear ? wrap((CW+1)'(front_r) + (CW+1)'(1)) : front_r;
  assign wr_idx = at_rear ? rear_idx : front_nxt;
  assign rd_idx = at_rear ? last_idx : front_r;
  assign cnt_nxt = push ? cnt_r + CW'(1) : pop ? cnt_r - CW'(1) : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      cnt_r   <= '0;
    end else begin
      front_r <= front_nxt;
      cnt_r   <= cnt_nxt;
    end
  end
  always_ff @(posedge clk) begin
    if (push) mem[wr_idx] <= wr_ent;
    if (pop)  rd_r <= mem[rd_idx];
  end
  assign rd_ent = rd_r;
  assign count  = cnt_r;
endmodule
`default_nettype wire

// File: rtl/core/three_class_queue_engine.sv
// ----------------------------------------------------------------------------
// three_class_queue_engine
// deque, fifo and sorted priority list behind one command port
// ----------------------------------------------------------------------------
// usage
//   a command beat is taken when start is high and busy is low; busy is
//   always low, so one command can be given every cycle
//   the result beat shows up on the out_ ports in the cycle after the
//   command is taken, marked by out_strobe for exactly one cycle; the
//   receiver cannot stall it; throughput 1 command per cycle; the priority
//   list is a chain of cells that all compare against the new key and
//   shift in the same cycle
//   cfg_we writes the server present mask; bit c-1 enables class c
//   reset clears all counts, pointers, valid bits and the mask; stored
//   entries are not cleared since only occupied slots are ever read
// ----------------------------------------------------------------------------
`default_nettype none
module three_class_queue_engine #(
  parameter int unsigned QUEUE_DEPTH = tcqe_pkg::QUEUE_DEPTH_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        start,
  output logic       busy,
  input  wire        in_op,
  input  wire  [1:0] in_queue_class,
  input  wire        in_at_rear,
  input  wire  [6:0] in_entry_key,
  input  wire  [7:0] in_entry_tag,
  input  wire        cfg_we,
  input  wire  [2:0] cfg_wdata,
  output logic       out_strobe,
  output logic [2:0] out_status,
  output logic [7:0] out_removed_tag,
  output logic [6:0] out_removed_key,
  output logic [4:0] out_class_count
);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH+1);
  localparam int unsigned N = QUEUE_DEPTH;

  logic [2:0] mask_r;
  logic [3:0] srv_vec;
  logic       go, srv, is_enq, is_deq;
  logic [1:0] q;
  logic [CW-1:0] cnt_d, cnt_f, cnt_p, cnt_sel, cnt_after;
  logic [tcqe_pkg::ENT_W-1:0] ent_d, ent_f, got;
  tcqe_pkg::status_t st;
  logic ok_enq, ok_deq;

  assign busy = 1'b0;
  assign go   = start & ~busy;
  assign q    = in_queue_class;
  // bit 0 stands for the invalid class and is never set
  assign srv_vec = {mask_r, 1'b0};
  assign srv  = srv_vec[q];
  assign is_enq = in_op == tcqe_pkg::OP_ENQ;
  assign is_deq = in_op == tcqe_pkg::OP_DEQ;

  always_comb begin
    case (q)
      tcqe_pkg::CLS_DEQUE: cnt_sel = cnt_d;
      tcqe_pkg::CLS_FIFO:  cnt_sel = cnt_f;
      tcqe_pkg::CLS_PRIO:  cnt_sel = cnt_p;
      default:             cnt_sel = '0;
    endcase
  end

  assign ok_enq = go & srv & is_enq & (cnt_sel != CW'(N));
  assign ok_deq = go & srv & is_deq & (cnt_sel != '0);

  always_comb begin
    if (q == tcqe_pkg::CLS_NONE)     st = tcqe_pkg::ST_BAD_CLS;
    else if (!srv)                   st = tcqe_pkg::ST_NO_SERV;
    else if (is_enq && !ok_enq)      st = tcqe_pkg::ST_FULL;
    else if (is_deq && !ok_deq)      st = tcqe_pkg::ST_EMPTY;
    else                             st = tcqe_pkg::ST_OK;
  end
  assign cnt_after = ok_enq ? cnt_sel + CW'(1) : ok_deq ? cnt_sel - CW'(1) : cnt_sel;

  tcqe_ring #(.DEPTH(QUEUE_DEPTH)) u_deque (
    .clk, .rst_n,
    .push(ok_enq & (q == tcqe_pkg::CLS_DEQUE)),
    .pop(ok_deq & (q == tcqe_pkg::CLS_DEQUE)),
    .at_rear(in_at_rear),
    .wr_ent({in_entry_key, in_entry_tag}), .rd_ent(ent_d), .count(cnt_d));

  // fifo pushes at the rear and pops at the front
  tcqe_ring #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk, .rst_n,
    .push(ok_enq & (q == tcqe_pkg::CLS_FIFO)),
    .pop(ok_deq & (q == tcqe_pkg::CLS_FIFO)),
    .at_rear(~(ok_deq & (q == tcqe_pkg::CLS_FIFO))),
    .wr_ent({in_entry_key, in_entry_tag}), .rd_ent(ent_f), .count(cnt_f));

  // priority list: chain of cells, slot 0 is the head
  tcqe_pkg::pq_cmd_t pcmd;
  wire [N-1:0] pv, pkeep, pgt;
  wire [tcqe_pkg::ENT_W-1:0] pe [N];
  assign pcmd.ins = ok_enq & (q == tcqe_pkg::CLS_PRIO);
  assign pcmd.pop = ok_deq & (q == tcqe_pkg::CLS_PRIO);
  assign pcmd.key = in_entry_key;
  assign pcmd.tag = in_entry_tag;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      logic pv_in, pk_in, pg_in, nv_in;
      logic [tcqe_pkg::ENT_W-1:0] pe_in, ne_in;
      if (g == 0) begin : g_head
        // nothing ahead of the head: it takes the new entry unless it keeps
        assign pv_in = 1'b0;
        assign pk_in = 1'b1;
        assign pg_in = 1'b1;
        assign pe_in = '0;
      end else begin : g_body
        assign pv_in = pv[g-1];
        assign pk_in = pkeep[g-1];
        assign pg_in = pgt[g-1];
        assign pe_in = pe[g-1];
      end
      if (g == N-1) begin : g_tail
        assign nv_in = 1'b0;
        assign ne_in = '0;
      end else begin : g_next
        assign nv_in = pv[g+1];
        assign ne_in = pe[g+1];
      end
      tcqe_pq_cell u_cell (
        .clk, .rst_n, .cmd(pcmd),
        .prev_valid(pv_in), .prev_keep(pk_in), .prev_gt(pg_in), .prev_ent(pe_in),
        .next_valid(nv_in), .next_ent(ne_in),
        .valid(pv[g]), .keep(pkeep[g]), .key_gt(pgt[g]), .ent(pe[g]));
    end
  endgenerate

  logic [CW-1:0] cnt_p_r;
  always_ff @(posedge clk) begin
    if (!rst_n) cnt_p_r <= '0;
    else if (pcmd.ins) cnt_p_r <= cnt_p_r + CW'(1);
    else if (pcmd.pop) cnt_p_r <= cnt_p_r - CW'(1);
  end
  assign cnt_p = cnt_p_r;

  // head entry captured on a priority pop
  logic [tcqe_pkg::ENT_W-1:0] head_r;
  always_ff @(posedge clk) begin
    if (pcmd.pop) head_r <= pe[0];
  end

  // configuration and result registers
  logic       strobe_r;
  logic [1:0] deq_cls_r;
  logic [2:0] status_r;
  logic [4:0] count_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r    <= '0;
      strobe_r  <= 1'b0;
      deq_cls_r <= tcqe_pkg::CLS_NONE;
    end else begin
      if (cfg_we) mask_r <= cfg_wdata;
      strobe_r  <= go;
      deq_cls_r <= ok_deq ? q : tcqe_pkg::CLS_NONE;
    end
  end
  always_ff @(posedge clk) begin
    status_r <= st;
    count_r  <= 5'(cnt_after);
  end

  // removed entry comes from the read register of the popped class
  always_comb begin
    case (deq_cls_r)
      tcqe_pkg::CLS_DEQUE: got = ent_d;
      tcqe_pkg::CLS_FIFO:  got = ent_f;
      tcqe_pkg::CLS_PRIO:  got = head_r;
      default:             got = '0;
    endcase
  end

  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_removed_tag = got[7:0];
  assign out_removed_key = got[14:8];
  assign out_class_count = count_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_p <= CW'(N)) else $error("priority count over depth");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> out_strobe) else $error("missing result");
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_p != '0) |-> pv[0]) else $error("head slot empty with count");
  a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(ok_enq && ok_deq)) else $error("enqueue and dequeue together");
endmodule
`default_nettype wire

// File: tb/tb_three_class_queue_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_three_class_queue_engine
// self-checking bench for the deque / fifo / priority queue engine
// ----------------------------------------------------------------------------
// command beats are queued by the stimulus process and driven by a clocked
// driver in random bursts; a clocked monitor compares every result beat with
// a prediction made by a behavioral copy of the three queues, which is updated
// at the moment a command is accepted
// ----------------------------------------------------------------------------
`default_nettype none
module tb_three_class_queue_engine;

  localparam int DEPTH = 16;

  typedef struct packed {
    logic       op;
    logic [1:0] qcls;
    logic       rear;
    logic [6:0] key;
    logic [7:0] tag;
  } cmd_t;

  typedef struct packed {
    tcqe_pkg::status_t status;
    logic [7:0] tag;
    logic [6:0] key;
    logic [4:0] count;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_op = 1'b0;
  logic [1:0] in_queue_class = '0;
  logic in_at_rear = 1'b0;
  logic [6:0] in_entry_key = '0;
  logic [7:0] in_entry_tag = '0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_wdata = '0;
  logic out_strobe;
  logic [2:0] out_status;
  logic [7:0] out_removed_tag;
  logic [6:0] out_removed_key;
  logic [4:0] out_class_count;

  three_class_queue_engine dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_queue_class(in_queue_class), .in_at_rear(in_at_rear),
    .in_entry_key(in_entry_key), .in_entry_tag(in_entry_tag),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_strobe(out_strobe), .out_status(out_status),
    .out_removed_tag(out_removed_tag), .out_removed_key(out_removed_key),
    .out_class_count(out_class_count)
  );

  always #6 clk = ~clk;

  // ---- shadow queues, kept as plain sv queues of {key, tag} ----
  logic [14:0] deque_q[$];
  logic [14:0] fifo_q[$];
  logic [14:0] prio_q[$];    // index 0 is served first
  logic [2:0] server_mask;

  cmd_t pending_cmds[$];     // beats waiting for the driver
  res_t expected_results[$]; // predictions waiting for the monitor
  int errors = 0;
  int results_seen = 0;
  int beats_sent = 0;
  int hold_off = 0;          // driver gap counter
  bit pause_drv = 1'b0;      // stimulus asks the driver to stop
  int ok_pops = 0;

  task automatic report(input string what, input res_t got, input res_t want);
    errors++;
    $display("mismatch %s: got st=%0d tag=%0d key=%0d cnt=%0d %s=%0d tag=%0d key=%0d cnt=%0d",
      what, got.status, got.tag, got.key, got.count,
      "want st", want.status, want.tag, want.key, want.count);
  endtask

  // queue model: apply one command and return its result beat
  function automatic res_t queue_apply(input cmd_t c);
    res_t r;
    int n;
    int pos;
    logic [14:0] ent;
    r = '{status: tcqe_pkg::ST_OK, tag: '0, key: '0, count: '0};
    ent = {c.key, c.tag};
    if (c.qcls == tcqe_pkg::CLS_NONE) begin
      r.status = tcqe_pkg::ST_BAD_CLS;
      return r;
    end
    n = (c.qcls == tcqe_pkg::CLS_DEQUE) ? deque_q.size() :
        (c.qcls == tcqe_pkg::CLS_FIFO) ? fifo_q.size() : prio_q.size();
    if (!server_mask[c.qcls - 1]) begin
      r.status = tcqe_pkg::ST_NO_SERV;
    end else if (c.op == tcqe_pkg::OP_ENQ) begin
      if (n >= DEPTH) begin
        r.status = tcqe_pkg::ST_FULL;
      end else if (c.qcls == tcqe_pkg::CLS_DEQUE) begin
        if (c.rear) deque_q.push_back(ent);
        else deque_q.push_front(ent);
      end else if (c.qcls == tcqe_pkg::CLS_FIFO) begin
        fifo_q.push_back(ent);
      end else begin
        // equal key lands right after the first holder of that key
        pos = n;
        for (int i = 0; i < n; i++) begin
          if (prio_q[i][14:8] <= c.key) begin
            pos = (prio_q[i][14:8] == c.key) ? i + 1 : i;
            break;
          end
        end
        prio_q.insert(pos, ent);
      end
    end else begin
      if (n == 0) begin
        r.status = tcqe_pkg::ST_EMPTY;
      end else begin
        if (c.qcls == tcqe_pkg::CLS_DEQUE)
          ent = c.rear ? deque_q.pop_back() : deque_q.pop_front();
        else if (c.qcls == tcqe_pkg::CLS_FIFO) ent = fifo_q.pop_front();
        else ent = prio_q.pop_front();
        r.tag = ent[7:0];
        r.key = ent[14:8];
        ok_pops++;
      end
    end
    r.count = (c.qcls == tcqe_pkg::CLS_DEQUE) ? deque_q.size() :
              (c.qcls == tcqe_pkg::CLS_FIFO) ? fifo_q.size() : prio_q.size();
    return r;
  endfunction

  // ---- driver: falling edge, bursts with random gaps ----
  always @(negedge clk) begin
    cmd_t c;
    if (rst_n && pending_cmds.size() > 0 && !pause_drv && hold_off == 0) begin
      c = pending_cmds[0];
      start <= 1'b1;
      in_op <= c.op;
      in_queue_class <= c.qcls;
      in_at_rear <= c.rear;
      in_entry_key <= c.key;
      in_entry_tag <= c.tag;
    end else begin
      start <= 1'b0;
      if (hold_off > 0) hold_off <= hold_off - 1;
    end
  end

  // acceptance at the rising edge: predict and pop the pending beat
  always @(posedge clk) begin
    cmd_t c;
    if (rst_n && start && !busy) begin
      c = {in_op, in_queue_class, in_at_rear, in_entry_key, in_entry_tag};
      expected_results.push_back(queue_apply(c));
      void'(pending_cmds.pop_front());
      beats_sent++;
      // end of burst now and then, gaps of random length
      if ($urandom_range(0, 7) == 0) hold_off <= $urandom_range(1, 6);
    end
  end

  // ---- monitor ----
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_strobe) begin
      got = '{status: tcqe_pkg::status_t'(out_status), tag: out_removed_tag,
              key: out_removed_key, count: out_class_count};
      results_seen++;
      if (expected_results.size() == 0) begin
        report("unexpected beat", got, got);
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status) report("status", got, want);
        else if (got.tag !== want.tag) report("removed_tag", got, want);
        else if (got.key !== want.key) report("removed_key", got, want);
        else if (got.count !== want.count) report("class_count", got, want);
      end
    end
  end

  function automatic cmd_t mk(input logic op, input logic [1:0] qc, input logic rear,
                              input logic [6:0] key, input logic [7:0] tag);
    cmd_t c;
    c = '{op: op, qcls: qc, rear: rear, key: key, tag: tag};
    return c;
  endfunction

  // wait until the driver has drained and every result arrived
  task automatic drain();
    while (pending_cmds.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_mask(input logic [2:0] m);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
    server_mask = m;
  endtask

  // random beat, mostly valid classes, biased toward keys that collide
  function automatic cmd_t rand_cmd(input int enq_bias);
    cmd_t c;
    c.op = ($urandom_range(0, 99) < enq_bias) ? tcqe_pkg::OP_ENQ : tcqe_pkg::OP_DEQ;
    c.qcls = ($urandom_range(0, 19) == 0) ? tcqe_pkg::CLS_NONE : 2'($urandom_range(1, 3));
    c.rear = 1'($urandom);
    c.key = ($urandom_range(0, 2) == 0) ? 7'($urandom_range(0, 3)) : 7'($urandom);
    c.tag = 8'($urandom);
    return c;
  endfunction

  initial begin
    server_mask = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // no servers at all, plus the invalid class
    pending_cmds.push_back(mk(tcqe_pkg::OP_ENQ, tcqe_pkg::CLS_DEQUE, 1'b0, 7'd5, 8'd1));
    pending_cmds.push_back(mk(tcqe_pkg::OP_DEQ, tcqe_pkg::CLS_PRIO, 1'b0, 7'd0, 8'd0));
    pending_cmds.push_back(mk(tcqe_pkg::OP_ENQ, tcqe_pkg::CLS_NONE, 1'b1, 7'd127, 8'd255));
    drain();

    set_mask(3'b111);
    // empty pops at both deque ends, fifo and priority
    pending_cmds.push_back(mk(tcqe_pkg::OP_DEQ, tcqe_pkg::CLS_DEQUE, 1'b0, 7'd0, 8'd0));
    pending_cmds.push_back(mk(tcqe_pkg::OP_DEQ, tcqe_pkg::CLS_DEQUE, 1'b1, 7'd0, 8'd0));
    pending_cmds.push_back(mk(tcqe_pkg::OP_DEQ, tcqe_pkg::CLS_FIFO, 1'b0, 7'd0, 8'd0));
    pending_cmds.push_back(mk(tcqe_pkg::OP_DEQ, tcqe_pkg::CLS_PRIO, 1'b0, 7'd0, 8'd0));
    // single entry popped at the deque rear
    pending_cmds.push_back(mk(tcqe_pkg::OP_ENQ, tcqe_pkg::CLS_DEQUE, 1'b0, 7'd127, 8'd255));
    pending_cmds.push_back(mk(tcqe_pkg::OP_DEQ, tcqe_pkg::CLS_DEQUE, 1'b1, 7'd0, 8'd0));
    // priority: equal keys, smaller than all, extremes
    pending_cmds.push_back(mk(tcqe_pkg::OP_ENQ, tcqe_pkg::CLS_PRIO, 1'b0, 7'd50, 8'd10));
    pending_cmds.push_back(mk(tcqe_pkg::OP_ENQ, tcqe_pkg::CLS_PRIO, 1'b0, 7'd50, 8'd11));
    pending_cmds.push_back(mk(tcqe_pkg::OP_ENQ, tcqe_pkg::CLS_PRIO, 1'b0, 7'd50, 8'd12));
    pending_cmds.push_back(mk(tcqe_pkg::OP_ENQ, tcqe_pkg::CLS_PRIO, 1'b0, 7'd0, 8'd0));
    pending_cmds.push_back(mk(tcqe_pkg::OP_ENQ, tcqe_pkg::CLS_PRIO, 1'b0, 7'd127, 8'd255));
    for (int i = 0; i < 6; i++)
      pending_cmds.push_back(mk(tcqe_pkg::OP_DEQ, tcqe_pkg::CLS_PRIO, 1'b0, '0, '0));
    // fill the fifo past full
    for (int i = 0; i < 17; i++)
      pending_cmds.push_back(mk(tcqe_pkg::OP_ENQ, tcqe_pkg::CLS_FIFO, 1'b0, 7'(i), 8'(i)));
    drain();

    set_mask(3'b010);
    pending_cmds.push_back(mk(tcqe_pkg::OP_DEQ, tcqe_pkg::CLS_FIFO, 1'b0, '0, '0));
    pending_cmds.push_back(mk(tcqe_pkg::OP_DEQ, tcqe_pkg::CLS_DEQUE, 1'b0, '0, '0));
    drain();

    // random phases over several masks
    for (int ph = 0; ph < 8; ph++) begin
      set_mask(ph == 7 ? 3'b111 : (ph == 0 ? 3'b000 : 3'($urandom_range(1, 7))));
      if (ph == 1 || ph == 5) set_mask(3'b111);
      for (int i = 0; i < 150; i++)
        pending_cmds.push_back(rand_cmd((i / 50) % 2 ? 35 : 65));
      // one hold-off until everything is back
      if (ph == 3) begin
        while (pending_cmds.size() > 75) @(posedge clk);
        pause_drv = 1'b1;
        @(negedge clk);
        while (expected_results.size() > 0) @(negedge clk);
        pause_drv = 1'b0;
      end
      drain();
    end
    repeat (5) @(posedge clk);
    $display("ran %0d command beats, %0d result beats, %0d successful pops",
             beats_sent, results_seen, ok_pops);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end
endmodule
`default_nettype wire
